[design/ack_tracking_table_unit_macros.svh]
// Assertion macros for the acknowledgment tracking table.
// Included by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef ACK_TRACKING_TABLE_UNIT_MACROS_SVH
`define ACK_TRACKING_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ATT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ATT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ATT_ASSERT_SAME(label, ante, cons)
`define ATT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/att_pkg.sv]
// Shared types and constants of the acknowledgment tracking table.
// No dependencies.
package att_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int PAGE_MAX_DEF    = 32;

    localparam int OP_W     = 3;
    localparam int SEQ_W    = 64;
    localparam int TIME_W   = 32;
    localparam int PAGE_W   = 64;
    localparam int SENDS_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int PLIM_W   = 6;
    localparam int PADDR_W  = 3;

    localparam logic [OP_W-1:0] OP_RECORD = 3'd0;
    localparam logic [OP_W-1:0] OP_AGE    = 3'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 3'd2;
    localparam logic [OP_W-1:0] OP_BUILD  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic REG_AGE_LIMIT  = 1'b0;
    localparam logic REG_PAGE_LIMIT = 1'b1;

    localparam logic [TIME_W-1:0]  AGE_LIMIT_RST  = 32'd5000;
    localparam logic [PLIM_W-1:0]  PAGE_LIMIT_RST = 6'd32;
    localparam logic [SENDS_W-1:0] SEND_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  seen;
        logic [SENDS_W-1:0] sends;
        logic [PAGE_W-1:0]  page;
    } entry_t;
endpackage

[design/att_if.sv]
// Request and result channel interfaces of the acknowledgment tracking table.
// Depends on att_pkg.
interface att_req_if import att_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SEQ_W-1:0]  seq_id;
    logic [TIME_W-1:0] now;
    logic [PAGE_W-1:0] page_id;
    modport source (output valid, operation, seq_id, now, page_id, input ready);
    modport sink (input valid, operation, seq_id, now, page_id, output ready);
endinterface

interface att_rsp_if import att_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_out;
    logic [COUNT_W-1:0]  count;
    logic                last;
    modport source (output valid, status, seq_out, count, last, input ready);
    modport sink (input valid, status, seq_out, count, last, output ready);
endinterface

[design/att_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[design/ack_tracking_table_unit.sv]
// Top level of the acknowledgment tracking table. Depends on att_pkg,
// att_req_if, att_rsp_if, att_ram and the assertion macro header.
//
// Every operation sweeps the occupied slots of one entry RAM, one slot per cycle
// behind a registered read (unless the stamping sweep stalls), then finishes in
// S_FIN once the output register is free. The next request is taken only back
// in S_IDLE. Building a page sweeps twice (count, then stamp) when the counting
// sweep finds unpaged entries, and the stamping sweep stalls while an emitted
// word still occupies the output register.
// Age-out and flush compact the table in the same sweep, writing kept entries
// back at a trailing pointer. No clearing pass is needed after reset.
`include "ack_tracking_table_unit_macros.svh"
module ack_tracking_table_unit import att_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PAGE_MAX    = PAGE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    att_req_if.sink            req,
    att_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(PAGE_MAX + 1);
    localparam int EW = $bits(entry_t);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [TIME_W-1:0] age_limit_reg;
    logic [PLIM_W-1:0] page_limit_reg;

    logic [1:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PAGE_W-1:0]   pid_reg, pid_next;
    logic [PW-1:0]       total_reg, total_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]       eidx_reg, eidx_next;
    logic                dv_reg, dv_next;
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       removed_reg, removed_next;
    logic                found_reg, found_next;
    logic [PW-1:0]       best_reg, best_next;
    entry_t              bword_reg, bword_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       emitted_reg, emitted_next;
    logic                pass2_reg, pass2_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SEQ_W-1:0]    seq_out_reg, seq_out_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                last_reg, last_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata;
    logic [EW-1:0] ram_rdata;
    entry_t        d;
    logic          aged, unpaged, stall;
    logic [CW-1:0] lim;
    entry_t        fresh;

    att_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            REG_AGE_LIMIT:  prdata = age_limit_reg;
            REG_PAGE_LIMIT: prdata = {26'd0, page_limit_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg  <= AGE_LIMIT_RST;
            page_limit_reg <= PAGE_LIMIT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_AGE_LIMIT:  age_limit_reg <= pwdata;
                REG_PAGE_LIMIT: page_limit_reg <= pwdata[PLIM_W-1:0];
                default:        age_limit_reg <= age_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        if (page_limit_reg == '0)
        begin
            lim = CW'(1);
        end
        else if (32'(page_limit_reg) > 32'(PAGE_MAX))
        begin
            lim = CW'(PAGE_MAX);
        end
        else
        begin
            lim = CW'(page_limit_reg);
        end
    end

    assign d       = entry_t'(ram_rdata);
    assign aged    = (now_reg - d.seen) > age_limit_reg;
    assign unpaged = (d.page == '0);
    assign stall   = pass2_reg && dv_reg && unpaged && (emitted_reg < cnt_reg) && out_valid_reg;

    always_comb
    begin
        fresh.seq   = seq_reg;
        fresh.seen  = now_reg;
        fresh.sends = '0;
        fresh.page  = '0;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.seq_out = seq_out_reg;
    assign rsp.count   = count_reg;
    assign rsp.last    = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        seq_next       = seq_reg;
        now_next       = now_reg;
        pid_next       = pid_reg;
        total_next     = total_reg;
        rd_ptr_next    = rd_ptr_reg;
        eidx_next      = eidx_reg;
        dv_next        = dv_reg;
        wr_ptr_next    = wr_ptr_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bword_next     = bword_reg;
        cnt_next       = cnt_reg;
        emitted_next   = emitted_reg;
        pass2_next     = pass2_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        seq_out_next   = seq_out_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = eidx_reg[AW-1:0];
        ram_wdata      = d;
        ram_re         = 1'b0;
        ram_raddr      = rd_ptr_reg[AW-1:0];

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.operation;
                    seq_next     = req.seq_id;
                    now_next     = req.now;
                    pid_next     = req.page_id;
                    rd_ptr_next  = '0;
                    dv_next      = 1'b0;
                    wr_ptr_next  = '0;
                    removed_next = '0;
                    found_next   = 1'b0;
                    cnt_next     = '0;
                    emitted_next = '0;
                    pass2_next   = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    if (dv_reg)
                    begin
                        case (op_reg)
                            OP_RECORD:
                            begin
                                if (!found_reg && d.seq == seq_reg)
                                begin
                                    found_next      = 1'b1;
                                    best_next       = eidx_reg;
                                    bword_next      = d;
                                    bword_next.seen = now_reg;
                                end
                            end
                            OP_AGE, OP_FLUSH:
                            begin
                                if ((op_reg == OP_AGE) ? aged : (d.page == pid_reg))
                                begin
                                    removed_next = removed_reg + 1'b1;
                                end
                                else
                                begin
                                    ram_we      = 1'b1;
                                    ram_waddr   = wr_ptr_reg[AW-1:0];
                                    wr_ptr_next = wr_ptr_reg + 1'b1;
                                end
                            end
                            OP_PICK:
                            begin
                                if (eidx_reg == '0 || d.sends < bword_reg.sends)
                                begin
                                    best_next  = eidx_reg;
                                    bword_next = d;
                                end
                            end
                            OP_BUILD:
                            begin
                                if (!pass2_reg)
                                begin
                                    if (unpaged && cnt_reg < lim)
                                    begin
                                        cnt_next = cnt_reg + 1'b1;
                                    end
                                end
                                else if (unpaged && emitted_reg < cnt_reg)
                                begin
                                    ram_we         = 1'b1;
                                    ram_wdata.page = pid_reg;
                                    out_valid_next = 1'b1;
                                    status_next    = ST_OK;
                                    seq_out_next   = d.seq;
                                    count_next     = COUNT_W'(cnt_reg);
                                    last_next      = (CW'(emitted_reg + 1'b1) == cnt_reg);
                                    emitted_next   = emitted_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                ram_we = 1'b0;
                            end
                        endcase
                    end
                    if (rd_ptr_reg < total_reg)
                    begin
                        ram_re      = 1'b1;
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                        eidx_next   = rd_ptr_reg;
                        dv_next     = 1'b1;
                    end
                    else
                    begin
                        dv_next = 1'b0;
                        if (!dv_reg)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg)
                begin
                    state_next   = S_IDLE;
                    status_next  = ST_OK;
                    seq_out_next = '0;
                    count_next   = '0;
                    last_next    = 1'b1;
                    out_valid_next = 1'b1;
                    case (op_reg)
                        OP_RECORD:
                        begin
                            if (found_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = best_reg[AW-1:0];
                                ram_wdata = bword_reg;
                            end
                            else if (total_reg == PW'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = total_reg[AW-1:0];
                                ram_wdata  = fresh;
                                total_next = total_reg + 1'b1;
                            end
                        end
                        OP_AGE, OP_FLUSH:
                        begin
                            total_next = wr_ptr_reg;
                            count_next = COUNT_W'(removed_reg);
                        end
                        OP_PICK:
                        begin
                            if (total_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = best_reg[AW-1:0];
                                ram_wdata = bword_reg;
                                if (bword_reg.sends != SEND_MAX)
                                begin
                                    ram_wdata.sends = bword_reg.sends + 1'b1;
                                end
                                seq_out_next = bword_reg.seq;
                            end
                        end
                        OP_BUILD:
                        begin
                            if (total_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pass2_reg)
                            begin
                                // Words were already sent during the stamping sweep.
                                out_valid_next = 1'b0;
                            end
                            else if (cnt_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                pass2_next     = 1'b1;
                                rd_ptr_next    = '0;
                                dv_next        = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            rd_ptr_reg    <= '0;
            dv_reg        <= 1'b0;
            wr_ptr_reg    <= '0;
            removed_reg   <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            emitted_reg   <= '0;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            rd_ptr_reg    <= rd_ptr_next;
            dv_reg        <= dv_next;
            wr_ptr_reg    <= wr_ptr_next;
            removed_reg   <= removed_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            emitted_reg   <= emitted_next;
            pass2_reg     <= pass2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        seq_reg     <= seq_next;
        now_reg     <= now_next;
        pid_reg     <= pid_next;
        eidx_reg    <= eidx_next;
        best_reg    <= best_next;
        bword_reg   <= bword_next;
        status_reg  <= status_next;
        seq_out_reg <= seq_out_next;
        count_reg   <= count_next;
        last_reg    <= last_next;
    end

    `ATT_ASSERT_SAME(a_total_bound, 1'b1, total_reg <= PW'(TABLE_DEPTH))
    `ATT_ASSERT_NEXT(a_start_scan, req.valid && req.ready, state_reg == S_SCAN)
    `ATT_ASSERT_SAME(a_compact_order, state_reg == S_SCAN, wr_ptr_reg <= rd_ptr_reg)
    `ATT_ASSERT_SAME(a_emit_bound, state_reg == S_SCAN && pass2_reg, emitted_reg <= cnt_reg && cnt_reg <= lim)
endmodule
